### sv/hnm_pkg.sv
// Shared constants, codes and types for the Hamming nearest-neighbor matcher.
// Used by hnm_front, hnm_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hnm_pkg;

    localparam int REF_DEPTH   = 256;
    localparam int DESC_BITS   = 256;
    localparam int DESC_BYTES  = DESC_BITS / 8;
    localparam int ADDR_W      = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CNT_W       = $clog2(REF_DEPTH + 1);
    localparam int GRP_BYTES   = 4;
    localparam int NUM_GRP     = (DESC_BYTES + GRP_BYTES - 1) / GRP_BYTES;
    localparam int GRP_W       = 6;
    localparam int DIST_W      = 9;
    localparam int CFG_W       = 6;
    localparam int CFG_RESET   = 32;
    localparam int ORD_W       = 16;
    localparam int IDX_W       = 8;
    localparam int CMD_W       = 2;
    localparam int IN_DATA_W   = 256;
    localparam int OUT_DATA_W  = 40;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [DESC_BITS-1:0] desc;
    } t_item;

    typedef struct packed {
        logic [ORD_W-1:0]  ordinal;
        logic              found;
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
        logic              overflowed;
    } t_result;

    function automatic logic [3:0] byte_pop(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, v[k]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### sv/hnm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the reference descriptors; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hnm_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 256
) (
    input  wire                                        i_clk,
    input  wire                                        i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                           i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/hnm_front.sv
// Front end: accepts input transactions, drops unused commands and queues
// the rest for the back end. Depends on hnm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hnm_front
    import hnm_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [IN_DATA_W-1:0] s_axis_tdata,
    input  wire  [CMD_W-1:0]     s_axis_tuser,
    output logic                 o_valid,
    output t_item                o_item,
    input  wire                  i_pop
);

    t_item      r_slot [QUEUE_DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_item      in_item;

    assign s_axis_tready = (r_cnt != 2'(QUEUE_DEPTH));
    assign o_valid       = (r_cnt != 2'd0);
    assign o_item        = r_slot[r_rptr];
    assign pop           = i_pop && o_valid;

    always_comb begin
        in_item.cmd  = s_axis_tuser;
        in_item.desc = s_axis_tdata[DESC_BITS-1:0];
        push         = 1'b0;
        unique case (s_axis_tuser)
            CMD_CLEAR, CMD_APPEND, CMD_QUERY: push = s_axis_tvalid && s_axis_tready;
            CMD_NONE:                         push = 1'b0;
            default:                          push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= in_item;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

### sv/hnm_back.sv
// Back end: executes clear, append and query, scanning the reference RAM
// through a short distance pipeline and holding the result register.
// Depends on hnm_pkg and hnm_ram.
`timescale 1ns / 1ps
`default_nettype none

module hnm_back
    import hnm_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [CFG_W-1:0] i_desc_bytes,
    input  wire              i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    output t_result          o_result,
    input  wire              i_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [CNT_W-1:0]      r_count;
    logic [ORD_W-1:0]      r_qcnt;
    logic                  r_ovf;
    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_issue;
    logic [DESC_BITS-1:0]  r_q;
    logic [DESC_BYTES-1:0] r_mask;
    logic [DESC_BYTES-1:0] n_mask;
    logic [DESC_BITS-1:0]  bit_mask;
    logic                  r_v0, r_v1, r_v2;
    logic [ADDR_W-1:0]     r_i0, r_i1, r_i2;
    logic [DESC_BITS-1:0]  r_x;
    logic [GRP_W-1:0]      r_grp [NUM_GRP];
    logic [GRP_W-1:0]      n_grp [NUM_GRP];
    logic [DIST_W-1:0]     sum;
    logic                  r_have;
    logic [DIST_W-1:0]     r_best_d;
    logic [ADDR_W-1:0]     r_best_i;
    logic                  r_out_valid;
    t_result               r_out;
    logic                  issue;
    logic                  we;
    logic [DESC_BITS-1:0]  rdata;
    logic                  load_out;

    hnm_ram #(
        .WIDTH (DESC_BITS),
        .DEPTH (REF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_item.desc),
        .i_raddr (r_issue[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    assign o_pop    = (r_state == ST_IDLE) && i_valid;
    assign we       = o_pop && (i_item.cmd == CMD_APPEND) &&
                      (r_count != CNT_W'(REF_DEPTH));
    assign issue    = (r_state == ST_SCAN) && (r_issue != r_n);
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        for (int b = 0; b < DESC_BYTES; b++) begin
            n_mask[b] = (CFG_W'(b) < i_desc_bytes);
            bit_mask[b*8 +: 8] = {8{r_mask[b]}};
        end
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_BYTES; j++) begin
                if (g * GRP_BYTES + j < DESC_BYTES) begin
                    n_grp[g] = n_grp[g] +
                        GRP_W'(byte_pop(r_x[(g * GRP_BYTES + j) * 8 +: 8]));
                end
            end
        end
        sum = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            sum = sum + DIST_W'(r_grp[g]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && i_item.cmd == CMD_QUERY) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !r_v0 && !r_v1 && !r_v2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i0 <= r_issue[ADDR_W-1:0];
        r_i1 <= r_i0;
        r_i2 <= r_i1;
        r_x  <= (rdata ^ r_q) & bit_mask;
        for (int g = 0; g < NUM_GRP; g++) begin
            r_grp[g] <= n_grp[g];
        end
        if (o_pop && i_item.cmd == CMD_QUERY) begin
            r_q    <= i_item.desc;
            r_mask <= n_mask;
            r_n    <= r_count;
        end
        if (load_out) begin
            r_out.ordinal       <= r_qcnt;
            r_out.found         <= r_have;
            r_out.best_index    <= IDX_W'(r_best_i);
            r_out.best_distance <= r_best_d;
            r_out.overflowed    <= r_ovf;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_qcnt      <= '0;
            r_ovf       <= 1'b0;
            r_issue     <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_have      <= 1'b0;
            r_best_d    <= '0;
            r_best_i    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v0    <= issue;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            if (issue) begin
                r_issue <= r_issue + CNT_W'(1);
            end
            if (o_pop) begin
                unique case (i_item.cmd)
                    CMD_CLEAR: begin
                        r_count <= '0;
                        r_qcnt  <= '0;
                    end
                    CMD_APPEND: begin
                        if (r_count == CNT_W'(REF_DEPTH)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    CMD_QUERY: begin
                        r_issue  <= '0;
                        r_have   <= 1'b0;
                        r_best_d <= '0;
                        r_best_i <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_v2 && (!r_have || sum < r_best_d)) begin
                r_have   <= 1'b1;
                r_best_d <= sum;
                r_best_i <= r_i2;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_qcnt      <= r_qcnt + ORD_W'(1);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### sv/hamming_nearest_matcher.sv
// Top level of the Hamming nearest-neighbor matcher: configuration register,
// front end queue, back end and result packing. Depends on hnm_pkg,
// hnm_front and hnm_back.
//
// The block keeps up to 256 reference descriptors of 256 bits. A clear or an
// append transaction completes in the back end without leaving the idle
// state; a query reads one stored reference per cycle from the reference
// RAM. A two-entry queue in front lets new transactions arrive while a query
// is scanning, and the result register lets the next transaction start while
// a result waits to be taken. Command 3 is accepted and ignored. The user
// must see that the desc_bytes register is written only while the block is
// idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module hamming_nearest_matcher
    import hnm_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_W-1:0]      i_cfg_wdata,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // word0, word1, word2, word3 (64 bits each).
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
    // command.
    input  wire  [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // query_ordinal, found, best_index, best_distance, overflowed, zero fill.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [CFG_W-1:0] r_desc_bytes;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc_bytes <= CFG_W'(CFG_RESET);
        end else if (i_cfg_we) begin
            r_desc_bytes <= i_cfg_wdata;
        end
    end

    hnm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_valid       (q_valid),
        .o_item        (q_item),
        .i_pop         (q_pop)
    );

    hnm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_bytes (r_desc_bytes),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .o_result     (result),
        .i_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, result.overflowed, result.best_distance,
                           result.best_index, result.found, result.ordinal};

endmodule

`default_nettype wire
